// File: hdl/dtbp_pkg.sv
// ----------------------------------------------------------------------------
// dtbp_pkg
// Shared types and character constants for the two-bit base packer.
// ----------------------------------------------------------------------------
package dtbp_pkg;

	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_N       = 8'h4E;
	localparam logic [7:0] CH_A_UPPER = 8'h41;
	localparam logic [7:0] CH_A_LOWER = 8'h61;
	localparam logic [7:0] CH_C_UPPER = 8'h43;
	localparam logic [7:0] CH_C_LOWER = 8'h63;
	localparam logic [7:0] CH_G_UPPER = 8'h47;
	localparam logic [7:0] CH_G_LOWER = 8'h67;
	localparam logic [7:0] CH_T_UPPER = 8'h54;
	localparam logic [7:0] CH_T_LOWER = 8'h74;

	localparam logic [1:0] CODE_A = 2'd0;
	localparam logic [1:0] CODE_C = 2'd1;
	localparam logic [1:0] CODE_G = 2'd2;
	localparam logic [1:0] CODE_T = 2'd3;

	localparam logic [1:0] SLOT_LAST = 2'd3;

	// classification of one character
	typedef struct packed {
		logic       is_base;
		logic [1:0] code;
		logic [7:0] markup_char;
	} class_t;

	// input stage word handed to the packer
	typedef struct packed {
		logic   valid;
		logic   last;
		class_t cls;
	} stage_t;

endpackage

// File: hdl/dtbp_classify.sv
// ----------------------------------------------------------------------------
// dtbp_classify
// Maps an ASCII character to its two-bit base code and markup character.
// ----------------------------------------------------------------------------
module dtbp_classify
	import dtbp_pkg::*;
(
	input  logic [7:0] base_char,
	output class_t     cls
);

	always_comb begin
		cls.is_base     = 1'b1;
		cls.code        = CODE_A;
		cls.markup_char = 8'd0;
		case (base_char)
			CH_A_UPPER, CH_A_LOWER: begin
				cls.code = CODE_A;
			end
			CH_C_UPPER, CH_C_LOWER: begin
				cls.code = CODE_C;
			end
			CH_G_UPPER, CH_G_LOWER: begin
				cls.code = CODE_G;
			end
			CH_T_UPPER, CH_T_LOWER: begin
				cls.code = CODE_T;
			end
			default: begin
				// anything else packs as A and is reported
				cls.is_base     = 1'b0;
				cls.code        = CODE_A;
				cls.markup_char = (base_char == CH_DOT) ? CH_N : base_char;
			end
		endcase
	end

endmodule

// File: hdl/dtbp_pack.sv
// ----------------------------------------------------------------------------
// dtbp_pack
// Packing state, offset counter and result register with output handshake.
// ----------------------------------------------------------------------------
module dtbp_pack
	import dtbp_pkg::*;
#(
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  stage_t      stg,
	output logic        advance,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        packed_valid,
	output logic [7:0]  packed_byte,
	output logic        markup_valid,
	output logic [7:0]  markup_char,
	output logic [15:0] markup_offset,
	output logic        seq_end
);

	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

	logic [5:0]             partial_q;
	logic [1:0]             slot_q;
	logic [OFFSET_BITS-1:0] offset_q;

	logic [7:0]  acc;
	logic [7:0]  pb;
	logic        pv;
	logic        emit;
	logic [15:0] offset_ext;

	// the input stage moves on whenever the result register can take a word
	assign advance = !out_valid || out_ready;

	assign acc        = {partial_q, stg.cls.code};
	assign offset_ext = 16'(offset_q);

	always_comb begin
		pv = 1'b0;
		pb = 8'd0;
		if (slot_q == SLOT_LAST) begin
			pv = 1'b1;
			pb = acc;
		end else if (stg.last) begin
			pv = 1'b1;
			case (slot_q)
				2'd0:    pb = {acc[1:0], 6'd0};
				2'd1:    pb = {acc[3:0], 4'd0};
				2'd2:    pb = {acc[5:0], 2'd0};
				default: pb = acc;
			endcase
		end
	end

	assign emit = pv || !stg.cls.is_base || stg.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			slot_q    <= '0;
			offset_q  <= '0;
		end else if (stg.valid && advance) begin
			if (stg.last) begin
				partial_q <= '0;
				slot_q    <= '0;
				offset_q  <= '0;
			end else begin
				if (slot_q == SLOT_LAST) begin
					partial_q <= '0;
					slot_q    <= '0;
				end else begin
					partial_q <= acc[5:0];
					slot_q    <= slot_q + 2'd1;
				end
				if (offset_q != OFFSET_MAX) begin
					offset_q <= offset_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= stg.valid && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && stg.valid && emit) begin
			packed_valid  <= pv;
			packed_byte   <= pb;
			markup_valid  <= !stg.cls.is_base;
			markup_char   <= stg.cls.markup_char;
			markup_offset <= stg.cls.is_base ? 16'd0 : offset_ext;
			seq_end       <= stg.last;
		end
	end

	a_word_has_content: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (packed_valid || markup_valid || seq_end))
		else $error("result word with no content");

	a_unused_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !packed_valid) |-> (packed_byte == 8'd0))
		else $error("packed_byte not zero without packed_valid");

	a_unused_markup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !markup_valid) |-> (markup_char == 8'd0 && markup_offset == 16'd0))
		else $error("markup fields not zero without markup_valid");

	a_last_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		(stg.valid && advance && stg.last) |=>
		(slot_q == 2'd0 && partial_q == 6'd0 && offset_q == '0))
		else $error("state not cleared after final base");

	a_full_byte_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(stg.valid && advance && slot_q == SLOT_LAST) |=> (out_valid && packed_valid))
		else $error("completed byte not emitted");

endmodule

// File: hdl/dna_two_bit_packer.sv
// ----------------------------------------------------------------------------
// dna_two_bit_packer
// Packs ASCII bases four to a byte, reporting non-ACGT characters as markup.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid, in_ready  | base_char, last
//  output   | out_valid, out_ready| packed_valid, packed_byte, markup_valid,
//           |                     | markup_char, markup_offset, seq_end
//
//  one word per cycle sustained while out_ready stays high; an accepted word
//  passes through the input register, then the result register, to the output
//  words that raise no result update the state and produce no output word
//  arst_n clears the packing state, offset counter and both valid flags
//  a stall on out_ready holds the result register and backs up into the input
//  register; in_ready falls only when both hold a word
// ----------------------------------------------------------------------------
module dna_two_bit_packer
	import dtbp_pkg::*;
#(
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  base_char,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        packed_valid,
	output logic [7:0]  packed_byte,
	output logic        markup_valid,
	output logic [7:0]  markup_char,
	output logic [15:0] markup_offset,
	output logic        seq_end
);

	logic       valid_s1;
	logic [7:0] base_char_s1;
	logic       last_s1;
	logic       advance;
	class_t     cls;
	stage_t     stg;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			base_char_s1 <= base_char;
			last_s1      <= last;
		end
	end

	dtbp_classify u_classify (
		.base_char (base_char_s1),
		.cls       (cls)
	);

	assign stg.valid = valid_s1;
	assign stg.last  = last_s1;
	assign stg.cls   = cls;

	dtbp_pack #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_pack (
		.clk           (clk),
		.arst_n        (arst_n),
		.stg           (stg),
		.advance       (advance),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.packed_valid  (packed_valid),
		.packed_byte   (packed_byte),
		.markup_valid  (markup_valid),
		.markup_char   (markup_char),
		.markup_offset (markup_offset),
		.seq_end       (seq_end)
	);

endmodule

// File: verif/dtbp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtbp_checker
// Watches both channels of the base packer, predicts every output word from
// the accepted input words and compares them field by field, in order.
// ----------------------------------------------------------------------------
module dtbp_checker
	import dtbp_pkg::*;
#(
	parameter int OFFSET_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  base_char,
	input  logic        last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        packed_valid,
	input  logic [7:0]  packed_byte,
	input  logic        markup_valid,
	input  logic [7:0]  markup_char,
	input  logic [15:0] markup_offset,
	input  logic        seq_end,
	output int          fail_count,
	output int          pending_cnt,
	output int          byte_cnt,
	output int          markup_cnt,
	output int          seq_cnt
);

	typedef struct packed {
		logic        pv;
		logic [7:0]  pb;
		logic        mv;
		logic [7:0]  mc;
		logic [15:0] mo;
		logic        se;
	} pack_word_t;

	logic [5:0]             codes_held;
	logic [1:0]             slot_cnt;
	logic [OFFSET_BITS-1:0] base_pos;
	pack_word_t             exp_words[$];
	pack_word_t             want_w;

	// advance the packing state by one base and queue the word it raises
	function automatic void pack_step(input logic [7:0] ch, input logic lst);
		pack_word_t w;
		logic [1:0] code;
		logic [7:0] acc;
		logic       is_base;
		w = '0;
		is_base = 1'b1;
		code = CODE_A;
		case (ch)
			CH_A_UPPER, CH_A_LOWER: code = CODE_A;
			CH_C_UPPER, CH_C_LOWER: code = CODE_C;
			CH_G_UPPER, CH_G_LOWER: code = CODE_G;
			CH_T_UPPER, CH_T_LOWER: code = CODE_T;
			default: is_base = 1'b0;
		endcase
		if (!is_base) begin
			w.mv = 1'b1;
			w.mc = (ch == CH_DOT) ? CH_N : ch;
			w.mo = 16'(base_pos);
		end
		acc = {codes_held, code};
		if (slot_cnt == SLOT_LAST) begin
			w.pv = 1'b1;
			w.pb = acc;
			codes_held = '0;
			slot_cnt = '0;
		end else if (lst) begin
			// flush: move the held codes up to the top, zeros below
			w.pv = 1'b1;
			w.pb = acc << (2 * (SLOT_LAST - slot_cnt));
		end else begin
			codes_held = acc[5:0];
			slot_cnt = slot_cnt + 2'd1;
		end
		if (base_pos != '1)
			base_pos = base_pos + 1'b1;
		if (lst) begin
			codes_held = '0;
			slot_cnt = '0;
			base_pos = '0;
		end
		w.se = lst;
		if (w.pv || w.mv || w.se)
			exp_words = {exp_words, w};
	endfunction

	task automatic check_field(input string fname, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h",
				$time, fname, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_held = '0;
			slot_cnt = '0;
			base_pos = '0;
			exp_words.delete();
		end else begin
			if (in_valid && in_ready)
				pack_step(base_char, last);
			if (out_valid && out_ready) begin
				if (exp_words.size() == 0) begin
					fail_count++;
					$display("%0t ns: unexpected word, expected none, %s %0h %0h %0h %0h %0h %0h",
						$time, "actual", packed_valid, packed_byte,
						markup_valid, markup_char, markup_offset, seq_end);
				end else begin
					want_w = exp_words.pop_front();
					check_field("packed_valid", 16'(want_w.pv), 16'(packed_valid));
					check_field("packed_byte", 16'(want_w.pb), 16'(packed_byte));
					check_field("markup_valid", 16'(want_w.mv), 16'(markup_valid));
					check_field("markup_char", 16'(want_w.mc), 16'(markup_char));
					check_field("markup_offset", want_w.mo, markup_offset);
					check_field("seq_end", 16'(want_w.se), 16'(seq_end));
					if (want_w.pv)
						byte_cnt++;
					if (want_w.mv)
						markup_cnt++;
					if (want_w.se)
						seq_cnt++;
				end
			end
		end
		pending_cnt = exp_words.size();
	end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives bases into the two-bit packer: short directed sequences, a long
// output hold-off, and random sequences with random gaps on both sides.
// Checking is in dtbp_checker.
// ----------------------------------------------------------------------------
module tb_top
	import dtbp_pkg::*;
();

	localparam int OFFSET_W     = 16;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 540;
	localparam int HOLD_CYCLES  = 160;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  base_char;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic        packed_valid;
	logic [7:0]  packed_byte;
	logic        markup_valid;
	logic [7:0]  markup_char;
	logic [15:0] markup_offset;
	logic        seq_end;

	logic in_acc = 1'b0;
	logic out_acc = 1'b0;
	bit   tx_gaps;
	bit   rx_gaps;
	bit   hold_req;
	int   cyc;
	int   fail_count;
	int   pending_cnt;
	int   byte_cnt;
	int   markup_cnt;
	int   seq_cnt;

	dna_two_bit_packer #(
		.OFFSET_BITS(OFFSET_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.base_char(base_char),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.packed_valid(packed_valid),
		.packed_byte(packed_byte),
		.markup_valid(markup_valid),
		.markup_char(markup_char),
		.markup_offset(markup_offset),
		.seq_end(seq_end)
	);

	dtbp_checker #(
		.OFFSET_BITS(OFFSET_W)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.base_char(base_char),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.packed_valid(packed_valid),
		.packed_byte(packed_byte),
		.markup_valid(markup_valid),
		.markup_char(markup_char),
		.markup_offset(markup_offset),
		.seq_end(seq_end),
		.fail_count(fail_count),
		.pending_cnt(pending_cnt),
		.byte_cnt(byte_cnt),
		.markup_cnt(markup_cnt),
		.seq_cnt(seq_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// handshakes as seen at the rising edge, read back at the falling edge
	always @(posedge clk) begin
		in_acc <= in_valid && in_ready;
		out_acc <= out_valid && out_ready;
	end

	initial begin
		cyc = 0;
		while (cyc < CYCLE_LIMIT)
			@(posedge clk) cyc++;
		$display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// output side: random stall before each word, or one long hold-off on request
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_gaps ? $urandom_range(0, 19) : 0;
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (!out_acc);
		end
	end

	task automatic push_base(input logic [7:0] ch, input logic lst);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		base_char <= ch;
		last <= lst;
		do @(negedge clk); while (!in_acc);
	endtask

	task automatic push_text(input string s, input bit ends);
		for (int i = 0; i < s.len(); i++)
			push_base(s[i], ends && (i == s.len() - 1));
	endtask

	// mostly bases in either case, some dots and arbitrary bytes
	function automatic logic [7:0] rand_char(input bit bases_only);
		case (bases_only ? $urandom_range(0, 7) : $urandom_range(0, 11))
			0: return CH_A_UPPER;
			1: return CH_A_LOWER;
			2: return CH_C_UPPER;
			3: return CH_C_LOWER;
			4: return CH_G_UPPER;
			5: return CH_G_LOWER;
			6: return CH_T_UPPER;
			7: return CH_T_LOWER;
			8: return CH_DOT;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		int seq_len;
		int rand_sent;
		in_valid = 1'b0;
		base_char = 8'h00;
		last = 1'b0;
		arst_n = 1'b0;
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		hold_req = 1'b0;
		rand_sent = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// full byte ending on the last base, then flushes from each slot
		push_text("ACGT", 1'b1);
		push_text("acgtg", 1'b1);
		push_base(8'h00, 1'b1);
		push_text("TT.", 1'b1);
		push_base(8'hFF, 1'b0);
		push_text("Nx", 1'b0);
		push_base(CH_T_UPPER, 1'b1);
		push_text("GA", 1'b1);
		push_base(8'h80, 1'b0);
		push_base(CH_DOT, 1'b1);

		// output held off while markup words keep arriving
		rx_gaps = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			push_base(8'($urandom_range(128, 255)), i == 39);

		while (rand_sent < RANDOM_ITEMS) begin
			tx_gaps = $urandom_range(0, 3) != 0;
			rx_gaps = $urandom_range(0, 3) != 0;
			seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
			for (int i = 0; i < seq_len; i++)
				push_base(rand_char(1'b0), i == seq_len - 1);
			rand_sent += seq_len;
		end

		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		in_valid <= 1'b0;
		while (pending_cnt != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);

		$display("checked %0d sequences: %0d packed bytes, %0d markup records",
			seq_cnt, byte_cnt, markup_cnt);
		$display("covered flushes from every slot, a %0d-cycle output hold-off %s",
			HOLD_CYCLES, "and random gaps on both sides");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
